/* rtl/tgard_pkg.sv */
// Shared types, constants and colour helpers for the TGA run-length pixel decoder.
package tgard_pkg;

    localparam int MAP_ENTRIES = 256;
    localparam int MAP_AW      = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

    // Item kinds on the input tuser bit
    localparam logic OP_STREAM = 1'b0;
    localparam logic OP_MAP    = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_COLOUR_MAPPED = 2'd0;
    localparam logic [1:0] REG_PIXEL_BYTES   = 2'd1;
    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd2;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd3;

    localparam int HDR_RUN_BIT  = 7;
    localparam int MIN_WIDTH    = 4;
    localparam int S_DATA_W     = 48;
    localparam int M_DATA_W     = 72;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;    // input item taken this cycle
        logic load_map;  // latch colour from the map read port
        logic emit;      // generate spans
    } cmd_t;

    typedef struct packed {
        logic start_pixel;  // current input byte completes a pixel
        logic mapped;       // that pixel needs a colour map lookup
        logic emit_done;    // this cycle ends the span sequence
        logic finished;     // final row written
    } sts_t;

    function automatic logic [2:0] eff_bytes(input logic [2:0] p);
        logic [2:0] r;
        r = p;
        if (p == 3'd0) r = 3'd1;
        if (p > 3'd4)  r = 3'd4;
        return r;
    endfunction

    // Blue/red swap for 3 and 4 byte pixels, then mask to the pixel size
    function automatic logic [31:0] fix_colour(input logic [31:0] c, input logic [2:0] p_raw);
        logic [2:0]  p;
        logic [31:0] r;
        p = eff_bytes(p_raw);
        r = c;
        if (p >= 3'd3) r = {c[31:24], c[7:0], c[15:8], c[23:16]};
        case (p)
            3'd1:    r = {24'd0, r[7:0]};
            3'd2:    r = {16'd0, r[15:0]};
            3'd3:    r = {8'd0, r[23:0]};
            default: r = r;
        endcase
        return r;
    endfunction

endpackage

/* rtl/tgard_ctrl.sv */
// Sequencer for the decoder: input acceptance, colour map lookup and span generation.
module tgard_ctrl
    import tgard_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && sts.start_pixel) begin
                    state_next = sts.mapped ? ST_LOOKUP : ST_EMIT;
                end
            end
            ST_LOOKUP: begin
                cmd.load_map = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                cmd.emit = 1'b1;
                if (sts.emit_done) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

/* rtl/tgard_dp.sv */
// Datapath: configuration, packet and pixel state, colour map and span output register.
module tgard_dp
    import tgard_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_wdata,
    input  logic                s_tuser,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  cmd_t                cmd,
    output sts_t                sts,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast,
    output logic                m_tuser
);

    // configuration
    logic        colour_mapped_reg;
    logic [2:0]  pixel_bytes_reg;
    logic [15:0] image_width_reg;
    logic [15:0] image_height_reg;

    // decode state
    logic        expect_header_reg, run_packet_reg, finished_reg;
    logic [7:0]  pixels_left_reg;
    logic [1:0]  byte_position_reg;
    logic [31:0] pixel_assembly_reg;
    logic [15:0] rows_done_reg, column_now_reg;
    logic [7:0]  emit_left_reg;
    logic [31:0] colour_reg;

    // colour map
    logic [31:0] map_mem [MAP_ENTRIES];
    logic [31:0] map_rd_reg;
    logic        map_rd_ok_reg;

    // output register
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic                m_last_reg, m_done_reg;

    logic [7:0]  in_byte, in_index;
    logic [31:0] in_colour;
    assign in_byte   = s_tdata[7:0];
    assign in_index  = s_tdata[15:8];
    assign in_colour = s_tdata[47:16];

    // ---- pixel assembly ----
    logic [1:0]  pos_new;
    logic [2:0]  need;
    logic [31:0] assembly_new;
    logic        complete, stream_ok, map_wr;
    logic [7:0]  pix_count, pl_after;

    assign pos_new      = byte_position_reg + 2'd1;
    assign need         = colour_mapped_reg ? 3'd1 : eff_bytes(pixel_bytes_reg);
    assign assembly_new = pixel_assembly_reg
                        | (32'(in_byte) << {byte_position_reg, 3'b000});
    assign complete     = (pos_new == 2'd0) || ({1'b0, pos_new} >= need);
    assign stream_ok    = (s_tuser == OP_STREAM) && !finished_reg;
    assign map_wr       = cmd.accept && (s_tuser == OP_MAP)
                        && (9'(in_index) < 9'(MAP_ENTRIES));
    assign pix_count    = (pixels_left_reg == 8'd0) ? 8'd1 : pixels_left_reg;
    assign pl_after     = run_packet_reg ? 8'd0 : (pix_count - 8'd1);

    // ---- span generation ----
    logic [15:0] w, h, take_full, col_sum, rows_inc;
    logic [7:0]  take;
    logic        start_fin, row_end, img_done, span_last, out_free, span_fire;

    assign w         = (image_width_reg < 16'(MIN_WIDTH)) ? 16'(MIN_WIDTH) : image_width_reg;
    assign h         = (image_height_reg == 16'd0) ? 16'd1 : image_height_reg;
    assign start_fin = rows_done_reg >= h;
    assign take_full = (column_now_reg < w) ? (w - column_now_reg) : 16'd1;
    assign take      = (take_full < {8'd0, emit_left_reg}) ? take_full[7:0] : emit_left_reg;
    assign col_sum   = column_now_reg + {8'd0, take};
    assign row_end   = col_sum >= w;
    assign rows_inc  = rows_done_reg + 16'd1;
    assign img_done  = row_end && (rows_inc >= h);
    assign span_last = (take == emit_left_reg) || img_done;
    assign out_free  = !m_valid_reg || m_tready;
    assign span_fire = cmd.emit && !start_fin && out_free;

    assign sts.start_pixel = stream_ok && !expect_header_reg && complete;
    assign sts.mapped      = colour_mapped_reg;
    assign sts.emit_done   = cmd.emit && (start_fin || (out_free && span_last));
    assign sts.finished    = finished_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            colour_mapped_reg <= 1'b0;
            pixel_bytes_reg   <= 3'd3;
            image_width_reg   <= 16'd4;
            image_height_reg  <= 16'd1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_COLOUR_MAPPED: colour_mapped_reg <= cfg_wdata[0];
                REG_PIXEL_BYTES:   pixel_bytes_reg   <= cfg_wdata[2:0];
                REG_IMAGE_WIDTH:   image_width_reg   <= cfg_wdata;
                REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // colour map, read every cycle at the index this byte would form
    always_ff @(posedge aclk) begin
        if (map_wr) map_mem[in_index[MAP_AW-1:0]] <= in_colour;
        map_rd_reg    <= map_mem[assembly_new[MAP_AW-1:0]];
        map_rd_ok_reg <= 9'(assembly_new[7:0]) < 9'(MAP_ENTRIES);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_header_reg  <= 1'b1;
            run_packet_reg     <= 1'b0;
            pixels_left_reg    <= 8'd0;
            byte_position_reg  <= 2'd0;
            pixel_assembly_reg <= 32'd0;
            rows_done_reg      <= 16'd0;
            column_now_reg     <= 16'd0;
            finished_reg       <= 1'b0;
            emit_left_reg      <= 8'd0;
        end else begin
            if (cmd.accept && stream_ok) begin
                if (expect_header_reg) begin
                    run_packet_reg     <= in_byte[HDR_RUN_BIT];
                    pixels_left_reg    <= {1'b0, in_byte[HDR_RUN_BIT-1:0]} + 8'd1;
                    byte_position_reg  <= 2'd0;
                    pixel_assembly_reg <= 32'd0;
                    expect_header_reg  <= 1'b0;
                end else if (complete) begin
                    byte_position_reg  <= 2'd0;
                    pixel_assembly_reg <= 32'd0;
                    emit_left_reg      <= run_packet_reg ? pix_count : 8'd1;
                    pixels_left_reg    <= pl_after;
                    if (pl_after == 8'd0) expect_header_reg <= 1'b1;
                end else begin
                    byte_position_reg  <= pos_new;
                    pixel_assembly_reg <= assembly_new;
                end
            end
            if (cmd.emit) begin
                if (start_fin) begin
                    finished_reg <= 1'b1;
                end else if (out_free) begin
                    emit_left_reg <= emit_left_reg - take;
                    if (row_end) begin
                        column_now_reg <= 16'd0;
                        rows_done_reg  <= rows_inc;
                    end else begin
                        column_now_reg <= col_sum;
                    end
                    if (img_done) finished_reg <= 1'b1;
                end
            end
        end
    end

    // colour of the pending pixel
    always_ff @(posedge aclk) begin
        if (cmd.accept && stream_ok && !expect_header_reg && complete) begin
            colour_reg <= fix_colour(assembly_new, pixel_bytes_reg);
        end else if (cmd.load_map) begin
            colour_reg <= fix_colour(map_rd_ok_reg ? map_rd_reg : 32'd0, pixel_bytes_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (span_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (span_fire) begin
            m_data_reg <= {colour_reg, take, column_now_reg, h - 16'd1 - rows_done_reg};
            m_last_reg <= span_last;
            m_done_reg <= img_done;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_done_reg;

endmodule

/* rtl/tga_rle_pixel_decoder.sv */
// Top level of the TGA run-length pixel decoder: sequencer plus datapath.
//
// Input stream (s_*): one item per handshake. s_tuser selects the kind: low
// for a packet data byte, high for a colour map entry write. Packet headers
// and pixel bytes flow in file order; each completed pixel becomes one or
// more row spans on the output stream (m_*), split where a row ends. The
// first decoded row lands in row image_height-1, counting down towards 0.
// Header and partial pixel bytes give no item and keep the input ready.
// A completing truecolor byte starts span generation directly; a
// colour-mapped one first passes the lookup state for the map read port.
// A pixel run then gives one span per cycle while the output is free,
// one per row it touches (up to 33 for a run of 128 over narrow rows);
// the input stays stalled until the last span is in the output register,
// then s_tready returns. Byte rate: 1 per cycle except for span sequences.
// The output register holds a span while m_tready is low; generation
// pauses until it is taken, input items keep waiting meanwhile.
// After the span flagged in m_tuser (image complete) all packet bytes are
// dropped until reset; map writes are still taken.
// Reset (aresetn low, synchronous) restores the default configuration and
// awaits a packet header; colour map contents are undefined until written.
// Configuration writes are to be made only while the block is idle.
module tga_rle_pixel_decoder
    import tgard_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // configuration write port
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_wdata,
    // input items
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // stream_byte[7:0], map_index[15:8], map_colour[47:16]
    input  logic                s_tuser,   // op
    // output spans
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // span_row[15:0], span_column[31:16],
                                           // span_count[39:32], span_colour[71:40]
    output logic                m_tlast,   // span_last
    output logic                m_tuser    // image_done
);

    cmd_t cmd;
    sts_t sts;

    tgard_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tgard_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // the image-complete span always ends its byte's spans
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("image complete span without span_last");

    // a span never carries zero pixels
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[39:32] != 8'd0)
        else $error("empty span");

    // once the final span is generated the decoder is marked finished
    a_done_sets_finished: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid && m_tuser) |-> sts.finished)
        else $error("finished flag missing after final row");

    // input is held off while spans are being generated
    a_no_accept_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !s_tready)
        else $error("input accepted during span generation");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the TGA run-length pixel decoder: random stream items against a span predictor.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tgard_pkg::*;

    // Packet header fields
    localparam logic [7:0] RUN_FLAG   = 8'h80;
    localparam logic [7:0] COUNT_MASK = 8'h7F;

    // Cycles with no handshake on either side before the run is abandoned. The
    // longest honest quiet stretch is the deliberate receiver hold-off.
    localparam int QUIET_LIMIT = 4000;
    // Idle cycles after the last expected span before a register write.
    localparam int SETTLE      = 8;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 9;
    // Pixel bytes come from a small pool, which keeps the number of map
    // entries that have to be written before use low.
    localparam int POOL_SIZE   = 16;

    typedef struct packed {
        logic        op;
        logic [7:0]  data_byte;
        logic [7:0]  map_index;
        logic [31:0] map_colour;
    } stream_item_t;

    typedef struct packed {
        logic [15:0] row;
        logic [15:0] col;
        logic [7:0]  count;
        logic [31:0] colour;
        logic        last;
        logic        done;
    } span_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [1:0]          cfg_index = '0;
    logic [15:0]         cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                s_tuser   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                m_tuser;

    tga_rle_pixel_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Decoder shadow: register copies and decode state
    // ------------------------------------------------------------------
    logic        cfg_mapped = 1'b0;
    logic [2:0]  cfg_pbytes = 3'd3;
    logic [15:0] cfg_width  = 16'd4;
    logic [15:0] cfg_height = 16'd1;

    logic        want_header  = 1'b1;
    logic        in_run       = 1'b0;
    logic [7:0]  px_left      = '0;
    logic [1:0]  byte_pos     = '0;
    logic [31:0] pix_acc      = '0;
    logic [15:0] rows_done    = '0;
    logic [15:0] col_now      = '0;
    logic        img_finished = 1'b0;
    logic [31:0] colour_table [MAP_ENTRIES];

    bit          map_primed [MAP_ENTRIES];  // entry already queued for a write
    logic [7:0]  byte_pool [POOL_SIZE];

    span_t        spans_due [$];     // spans the decoder still owes, oldest first
    stream_item_t items_to_send [$]; // items waiting for the driver

    int   items_sent  = 0;
    int   items_taken = 0;
    int   spans_taken = 0;
    int   error_count = 0;
    int   tx_wait     = 0;
    int   rx_wait     = 0;
    int   quiet       = 0;
    bit   full_rate   = 0;  // both sides run gap-free while set
    bit   held_off    = 0;
    stream_item_t on_wire;

    // 0 behaves as 1, anything above 4 as 4
    function automatic int pixel_size(input logic [2:0] p);
        if (p == 3'd0) return 1;
        if (p > 3'd4) return 4;
        return p;
    endfunction

    // File byte order is B,G,R(,A): swap bytes 0 and 2 for 3/4 byte pixels,
    // then keep only the bytes that the pixel size covers.
    function automatic logic [31:0] as_stored(input logic [31:0] c);
        int          p;
        logic [31:0] r;
        p = pixel_size(cfg_pbytes);
        r = c;
        if (p >= 3) r = {c[31:24], c[7:0], c[15:8], c[23:16]};
        if (p < 4) r = r & ((32'h1 << (8 * p)) - 32'h1);
        return r;
    endfunction

    function automatic int gap_length(input bit fast);
        int r;
        if (fast) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pool_byte();
        return byte_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // Lay n pixels of colour c out as row spans; a span never crosses a row end.
    // A column already past the width (width shrunk mid-row) gives a one
    // pixel span that closes the row.
    task automatic emit_spans(input int n, input logic [31:0] c);
        int    w, h, take, k;
        span_t sp;
        w = (cfg_width < 16'd4) ? 4 : cfg_width;
        h = (cfg_height == 16'd0) ? 1 : cfg_height;
        k = 0;
        while (n > 0 && !img_finished) begin
            if (rows_done >= h) begin
                img_finished = 1'b1;
            end else begin
                take = (col_now < w) ? w - col_now : 1;
                if (take > n) take = n;
                sp.row    = 16'(h - 1 - rows_done);
                sp.col    = col_now;
                sp.count  = 8'(take);
                sp.colour = c;
                sp.last   = 1'b0;
                sp.done   = 1'b0;
                col_now   = 16'(col_now + take);
                n         = n - take;
                if (col_now >= w) begin
                    col_now   = '0;
                    rows_done = rows_done + 16'd1;
                    if (rows_done >= h) begin
                        img_finished = 1'b1;
                        sp.done      = 1'b1;
                    end
                end
                spans_due.push_back(sp);
                k++;
            end
        end
        if (k > 0) spans_due[spans_due.size() - 1].last = 1'b1;
    endtask

    // Advance the shadow by one accepted item
    task automatic decode_item(input stream_item_t it);
        logic [31:0] colour;
        int          need;
        if (it.op == OP_MAP) begin
            if (it.map_index < MAP_ENTRIES) colour_table[it.map_index] = it.map_colour;
            return;
        end
        if (img_finished) return;
        if (want_header) begin
            in_run      = it.data_byte[HDR_RUN_BIT];
            px_left     = (it.data_byte & COUNT_MASK) + 8'd1;
            byte_pos    = '0;
            pix_acc     = '0;
            want_header = 1'b0;
            return;
        end
        pix_acc  = pix_acc | ({24'd0, it.data_byte} << (8 * byte_pos));
        byte_pos = byte_pos + 2'd1;
        need     = cfg_mapped ? 1 : pixel_size(cfg_pbytes);
        if (byte_pos != 2'd0 && byte_pos < need) return;

        colour   = cfg_mapped ? colour_table[pix_acc[7:0]] : pix_acc;
        colour   = as_stored(colour);
        byte_pos = '0;
        pix_acc  = '0;
        if (px_left == 8'd0) px_left = 8'd1;
        if (in_run) begin
            emit_spans(int'(px_left), colour);
            px_left = '0;
        end else begin
            emit_spans(1, colour);
            px_left = px_left - 8'd1;
        end
        if (px_left == 8'd0) want_header = 1'b1;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count < 100)
            $display("%0t: span %0d %s: got %h, expected %h", $time, spans_taken, what, got, want);
    endtask

    task automatic check_span();
        span_t want;
        if (spans_due.size() == 0) begin
            report_mismatch("arrived with none expected", m_tdata[31:0], 32'd0);
            return;
        end
        want = spans_due.pop_front();
        if (m_tdata[15:0]  !== want.row)    report_mismatch("row", m_tdata[15:0], want.row);
        if (m_tdata[31:16] !== want.col)    report_mismatch("column", m_tdata[31:16], want.col);
        if (m_tdata[39:32] !== want.count)  report_mismatch("count", m_tdata[39:32], want.count);
        if (m_tdata[71:40] !== want.colour) report_mismatch("colour", m_tdata[71:40], want.colour);
        if (m_tlast !== want.last)          report_mismatch("last flag", m_tlast, want.last);
        if (m_tuser !== want.done)          report_mismatch("image done", m_tuser, want.done);
    endtask

    // ------------------------------------------------------------------
    // Driver: one item per handshake, random gaps between items
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_item(on_wire);
                items_taken++;
            end
            // only move on once the current item is gone
            if (!s_tvalid || s_tready) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    s_tvalid <= 1'b0;
                end else if (items_to_send.size() > 0) begin
                    on_wire  = items_to_send.pop_front();
                    s_tdata  <= {on_wire.map_colour, on_wire.map_index, on_wire.data_byte};
                    s_tuser  <= on_wire.op;
                    s_tvalid <= 1'b1;
                    tx_wait  = gap_length(full_rate);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, one long hold-off while items keep
    // coming so that the output register fills and the input stalls
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_span();
                spans_taken++;
            end
            if (!held_off && spans_taken >= 20 && items_to_send.size() > 4) begin
                held_off = 1;
                rx_wait  = 400;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                rx_wait  = gap_length(full_rate);
            end
        end
    end

    // Watchdog: too long without a handshake on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("FAIL tga_rle_pixel_decoder");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_item(input logic op, input logic [7:0] b, input logic [7:0] idx,
                             input logic [31:0] colour);
        stream_item_t it;
        it.op         = op;
        it.data_byte  = b;
        it.map_index  = idx;
        it.map_colour = colour;
        if (op == OP_MAP) map_primed[idx] = 1'b1;
        items_to_send.push_back(it);
        items_sent++;
    endtask

    // Any stream byte may end up as a colour index, so its map entry is
    // written before the byte goes out. Map fields are don't-care on a
    // stream byte; randomise them anyway.
    task automatic send_byte(input logic [7:0] b);
        if (!map_primed[b]) send_item(OP_MAP, 8'($urandom), b, $urandom);
        send_item(OP_STREAM, b, 8'($urandom), $urandom);
    endtask

    // Well-formed packet of n pixels (1..128) with pixel bytes from the pool
    task automatic send_packet(input logic run, input int n);
        int         bytes, pixels;
        logic [7:0] header;
        bytes  = cfg_mapped ? 1 : pixel_size(cfg_pbytes);
        pixels = run ? 1 : n;
        header = 8'(n - 1) & COUNT_MASK;
        if (run) header = header | RUN_FLAG;
        send_byte(header);
        repeat (pixels * bytes) send_byte(pool_byte());
    endtask

    // Mostly packets with random content; some stray bytes to knock the
    // packet framing out of step, and the odd map rewrite.
    task automatic random_traffic(input int budget);
        int   first, r, n;
        logic run;
        first = items_sent;
        while (items_sent - first < budget) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                send_item(OP_MAP, 8'($urandom), 8'($urandom), $urandom);
            end else if (r < 18) begin
                send_byte(pool_byte());
            end else begin
                run = ($urandom_range(0, 99) < 60);
                r   = $urandom_range(0, 99);
                n   = (r < 70) ? $urandom_range(1, 8) :
                      (r < 90) ? $urandom_range(9, 64) : $urandom_range(65, 128);
                // long literal packets cost one item per byte; keep them short
                if (!run && n > 12) n = $urandom_range(1, 12);
                send_packet(run, n);
            end
        end
    endtask

    // Block idle: every item taken, every span in, plus a few spare cycles
    task automatic wait_idle();
        while (items_taken != items_sent || spans_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
    endtask

    task automatic set_config(input logic mapped, input logic [2:0] pbytes,
                              input logic [15:0] width, input logic [15:0] height);
        cfg_mapped = mapped;
        cfg_pbytes = pbytes;
        cfg_width  = width;
        cfg_height = height;
        write_reg(REG_COLOUR_MAPPED, {15'd0, mapped});
        write_reg(REG_PIXEL_BYTES, {13'd0, pbytes});
        write_reg(REG_IMAGE_WIDTH, width);
        write_reg(REG_IMAGE_HEIGHT, height);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : sequence_main
        int          i, p, height_lo;
        logic [2:0]  pb;
        logic [15:0] wd;

        for (i = 0; i < POOL_SIZE; i++) byte_pool[i] = 8'($urandom);
        byte_pool[0] = 8'h00;
        byte_pool[1] = 8'hFF;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Extremes at both ends of the colour map
        send_item(OP_MAP, 8'h00, 8'h00, 32'h0);
        send_item(OP_MAP, 8'h00, 8'(MAP_ENTRIES - 1), 32'hFFFF_FFFF);
        wait_idle();

        // Directed, truecolour 3 bytes, narrowest rows, tallest image.
        set_config(1'b0, 3'd3, 16'd4, 16'hFFFF);
        send_byte(8'h00);                    // literal of one, all-zero pixel
        repeat (3) send_byte(8'h00);
        send_byte(8'hFF);                    // run of 128 from column 1: 33 spans
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hA5);
        send_packet(1'b0, 3);                // short literal
        wait_idle();

        // Directed, colour-mapped with 4 byte entries, odd width
        set_config(1'b1, 3'd4, 16'd5, 16'hFFFF);
        send_byte(8'h80);                    // run of one from the top entry
        send_byte(8'hFF);
        send_byte(8'h01);                    // literal of two, bottom and middle
        send_byte(8'h00);
        send_byte(8'h80);
        wait_idle();

        // Random phases. Each takes a new setting; the column and any half
        // built pixel carry over, so a shrunk width or pixel size is hit
        // mid-row. Height always stays clear of the rows a phase can use.
        for (p = 0; p < PHASES; p++) begin
            full_rate = (p % 3 == 2);
            case (p)
                0:       begin pb = 3'd1; wd = 16'd4;                      end
                1:       begin pb = 3'd3; wd = 16'hFFFF;                   end
                2:       begin pb = 3'd4; wd = 16'd2;                      end
                3:       begin pb = 3'd2; wd = 16'($urandom_range(5, 40)); end
                4:       begin pb = 3'd0; wd = 16'd4;                      end
                5:       begin pb = 3'd7; wd = 16'd300;                    end
                6:       begin pb = 3'd5; wd = 16'd0;                      end
                default: begin pb = 3'd3; wd = 16'($urandom_range(4, 12)); end
            endcase
            height_lo = rows_done + 33 * PHASE_ITEMS + 10;
            set_config(p % 3 == 1, pb, wd,
                       (p == 0) ? 16'hFFFF : 16'($urandom_range(height_lo, 65535)));
            random_traffic(PHASE_ITEMS);
            wait_idle();
        end

        // Closing phase: two rows left, long runs until the last row fills;
        // the rest of the run that finishes the image is dropped.
        full_rate = 0;
        set_config(1'b0, 3'd3, 16'd4, rows_done + 16'd2);
        while (!img_finished) begin
            send_packet(1'b1, 128);
            wait_idle();
        end

        // After the image: stream bytes are ignored, map writes still taken
        send_packet(1'b1, 10);
        send_item(OP_MAP, 8'($urandom), 8'($urandom), $urandom);
        send_packet(1'b0, 2);
        wait_idle();
        repeat (20) @(posedge aclk);

        if (error_count == 0) begin
            $display("PASS tga_rle_pixel_decoder");
        end else begin
            $display("FAIL tga_rle_pixel_decoder");
        end
        $finish;
    end

endmodule

`default_nettype wire
